// File: rtl/core/tws_pkg.sv
// Shared widths, register codes and stage payload types of the table waveshaper.
package tws_pkg;

    localparam int SAMPLE_W    = 17;
    localparam int ENTRY_IDX_W = 8;
    localparam int GAIN_W      = 17;
    localparam int ENTRIES_W   = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = 35;
    localparam int BASE_W      = 19;
    localparam int MIX_W       = 37;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam logic [GAIN_W-1:0]           GAIN_ONE    = 17'h10000;
    localparam logic [GAIN_W-1:0]           GAIN_RST    = 17'h00000;
    localparam logic [ENTRIES_W-1:0]        ENTRIES_RST = 9'd256;
    localparam logic signed [SAMPLE_W-1:0]  UNIT_POS    = 17'sh08000;
    localparam logic signed [SAMPLE_W-1:0]  UNIT_NEG    = -17'sh08000;
    localparam logic signed [SAMPLE_W:0]    UNIT_OFS    = 18'sh08000;
    localparam logic signed [SAMPLE_W-1:0]  OUT_MIN     = -17'sh10000;
    localparam logic signed [SAMPLE_W-1:0]  OUT_MAX     = 17'sh0ffff;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIX_GAIN       = 2'd0,
        REG_ENTRIES_IN_USE = 2'd1
    } cfg_reg_t;

    // Request as it leaves the index stage.
    typedef struct packed {
        logic                        is_write;
        logic                        below;
        logic                        above;
        logic signed [SAMPLE_W-1:0]  x;
        logic [ENTRY_IDX_W-1:0]      wr_index;
        logic signed [SAMPLE_W-1:0]  wr_value;
    } tws_req_t;

    // Interpolation terms handed to the mixer.
    typedef struct packed {
        logic signed [PROD_W-1:0]    prod;
        logic signed [BASE_W-1:0]    base;
        logic signed [SAMPLE_W-1:0]  x;
    } tws_interp_t;

endpackage

// File: rtl/core/tws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tws_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/tws_index.sv
// Index stage: range check of the sample and segment position from sample times entry count.
module tws_index
    import tws_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int NW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_req_type,
    input  logic signed [SAMPLE_W-1:0]  in_sample,
    input  logic [ENTRY_IDX_W-1:0]      in_entry_index,
    input  logic signed [SAMPLE_W-1:0]  in_entry_value,
    input  logic [NW-1:0]               n_eff,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tws_req_t                    out_req,
    output logic [NW-1:0]               out_idx,
    output logic [FRAC_W-1:0]           out_frac
);

    localparam int PW = SAMPLE_W + NW;

    logic                    en;
    logic signed [SAMPLE_W:0] u_sum;
    logic [SAMPLE_W-1:0]     u;
    logic [PW-1:0]           p;
    tws_req_t                req_next;

    logic                    valid_reg;
    tws_req_t                req_reg;
    logic [NW-1:0]           idx_reg;
    logic [FRAC_W-1:0]       frac_reg;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // Shift into 0..2 in Q.15 and scale by the entry count.
    assign u_sum = SAMPLE_W'(0) + {in_sample[SAMPLE_W-1], in_sample} + UNIT_OFS;
    assign u     = u_sum[SAMPLE_W-1:0];
    assign p     = PW'(u) * PW'(n_eff);

    always_comb begin
        req_next.is_write = in_req_type;
        req_next.below    = (in_sample < UNIT_NEG);
        req_next.above    = (in_sample > UNIT_POS);
        req_next.x        = in_sample;
        req_next.wr_index = in_entry_index;
        req_next.wr_value = in_entry_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            req_reg  <= req_next;
            idx_reg  <= p[FRAC_W +: NW];
            frac_reg <= p[FRAC_W-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign out_req   = req_reg;
    assign out_idx   = idx_reg;
    assign out_frac  = frac_reg;

`ifndef SYNTHESIS
    a_region_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> !(req_reg.below && req_reg.above))
        else $error("sample flagged both below and above the table span");
`endif

endmodule

// File: rtl/core/tws_lookup.sv
// Table stage: address pick, dual table read or entry write, and the interpolation product.
module tws_lookup
    import tws_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int NW = $clog2(TABLE_DEPTH + 1),
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  tws_req_t           in_req,
    input  logic [NW-1:0]      in_idx,
    input  logic [FRAC_W-1:0]  in_frac,
    input  logic [NW-1:0]      n_eff,
    output logic               out_valid,
    input  logic               out_ready,
    output tws_interp_t        out_item
);

    logic [NW-1:0]      nm1;
    logic [NW-1:0]      idx_inc;
    logic               pin;
    logic [AW-1:0]      addr_a;
    logic [AW-1:0]      addr_b;
    logic [AW-1:0]      wr_addr;
    logic [FRAC_W-1:0]  frac_eff;
    logic               wr_ok;
    logic               en_b;
    logic               en_c;
    logic               ram_we;
    logic               ram_re;
    logic [SAMPLE_W-1:0] a_q;
    logic [SAMPLE_W-1:0] b_q;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [FRAC_W:0]     frac_s;

    logic                       vb_reg;
    logic signed [SAMPLE_W-1:0] xb_reg;
    logic [FRAC_W-1:0]          fracb_reg;
    logic                       vc_reg;
    tws_interp_t                item_reg;

    // Pin to one entry outside the span or at the last segment; zero fraction keeps it exact.
    assign nm1      = n_eff - NW'(1);
    assign idx_inc  = in_idx + NW'(1);
    assign pin      = in_req.below || in_req.above || (in_idx >= nm1);
    assign addr_a   = in_req.below ? '0 : (pin ? AW'(nm1) : AW'(in_idx));
    assign addr_b   = pin ? addr_a : AW'(idx_inc);
    assign frac_eff = pin ? '0 : in_frac;

    assign wr_ok   = (32'(in_req.wr_index) < 32'(TABLE_DEPTH));
    assign wr_addr = AW'(in_req.wr_index);

    assign en_c     = !vc_reg || out_ready;
    assign en_b     = !vb_reg || en_c;
    assign in_ready = en_b;

    // Writes and reads take the same stage, so table access follows item order.
    assign ram_re = en_b && in_valid && !in_req.is_write;
    assign ram_we = en_b && in_valid && in_req.is_write && wr_ok;

    tws_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_lo (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (in_req.wr_value),
        .re    (ram_re),
        .raddr (addr_a),
        .rdata (a_q)
    );

    tws_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_hi (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (in_req.wr_value),
        .re    (ram_re),
        .raddr (addr_b),
        .rdata (b_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (en_b) begin
                vb_reg <= in_valid && !in_req.is_write;
            end
            if (en_c) begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            xb_reg    <= in_req.x;
            fracb_reg <= frac_eff;
        end
    end

    assign diff   = $signed({b_q[SAMPLE_W-1], b_q}) - $signed({a_q[SAMPLE_W-1], a_q});
    assign frac_s = $signed({1'b0, fracb_reg});

    always_ff @(posedge aclk) begin
        if (en_c && vb_reg) begin
            item_reg.prod <= PROD_W'(diff) * PROD_W'(frac_s);
            item_reg.base <= BASE_W'($signed(a_q)) - BASE_W'(xb_reg);
            item_reg.x    <= xb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_item  = item_reg;

`ifndef SYNTHESIS
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !ram_re)
        else $error("table written and read by the same step");

    a_sample_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (en_b && in_valid && !in_req.is_write) |=> vb_reg)
        else $error("sample lost between index and table stage");
`endif

endmodule

// File: rtl/core/tws_mix.sv
// Mixer: shaped value from the interpolation terms, wet/dry blend, rounding and saturation.
module tws_mix
    import tws_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tws_interp_t                 in_item,
    input  logic [GAIN_W-1:0]           gain,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  out_sample
);

    logic                       en_d;
    logic                       en_e;
    logic                       en_f;
    logic signed [PROD_W-1:0]   rnd;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [MIX_W-1:0]    acc;
    logic signed [MIX_W-1:0]    y;
    logic signed [SAMPLE_W-1:0] y_next;

    logic                       vd_reg;
    logic signed [BASE_W-1:0]   e_reg;
    logic signed [SAMPLE_W-1:0] xd_reg;
    logic                       ve_reg;
    logic signed [MIX_W-1:0]    m_reg;
    logic signed [SAMPLE_W-1:0] xe_reg;
    logic                       vf_reg;
    logic signed [SAMPLE_W-1:0] y_reg;

    assign en_f     = !vf_reg || out_ready;
    assign en_e     = !ve_reg || en_f;
    assign en_d     = !vd_reg || en_e;
    assign in_ready = en_d;

    // e = shaped - dry; out = x + round(e * g), so zero gain passes x exactly.
    assign rnd    = in_item.prod + PROD_W'(32768);
    assign gain_s = $signed({1'b0, gain});
    assign acc    = (MIX_W'(xe_reg) <<< FRAC_W) + m_reg + MIX_W'(32768);
    assign y      = acc >>> FRAC_W;

    always_comb begin
        priority if (y < MIX_W'(OUT_MIN)) begin
            y_next = OUT_MIN;
        end else if (y > MIX_W'(OUT_MAX)) begin
            y_next = OUT_MAX;
        end else begin
            y_next = SAMPLE_W'(y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end else begin
            if (en_d) begin
                vd_reg <= in_valid;
            end
            if (en_e) begin
                ve_reg <= vd_reg;
            end
            if (en_f) begin
                vf_reg <= ve_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_d && in_valid) begin
            e_reg  <= in_item.base + BASE_W'(rnd >>> FRAC_W);
            xd_reg <= in_item.x;
        end
        if (en_e && vd_reg) begin
            m_reg  <= MIX_W'(e_reg) * MIX_W'(gain_s);
            xe_reg <= xd_reg;
        end
        if (en_f && ve_reg) begin
            y_reg <= y_next;
        end
    end

    assign out_valid  = vf_reg;
    assign out_sample = y_reg;

endmodule

// File: rtl/core/table_waveshaper_saturation.sv
// Top level of the table waveshaper: config registers, index, table and mix stages.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | s_valid / s_ready  | s_req_type, s_sample, s_entry_index, s_entry_value
//  result   | m_valid / m_ready  | m_shaped_sample
//  config   | cfg_wr_en          | cfg_index, cfg_data
//
//  One item enters per clock while s_ready is high. A sample item passes through the
//  index multiply, table read, interpolation multiply, shaped-value sum, blend multiply,
//  round and saturate, each behind its own register stage.
//  A table write item retires at the table stage and returns no result.
//  Reset clears the valid bits and the config registers (gain 0, 256 entries); the
//  table itself is not cleared and must be written before samples use it.
//  Each stage holds only while it is full and the stage after it is stalled, so a
//  waiting result stalls nothing until every stage in front of it holds an item.
module table_waveshaper_saturation
    import tws_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic signed [SAMPLE_W-1:0]  s_sample,
    input  logic [ENTRY_IDX_W-1:0]      s_entry_index,
    input  logic signed [SAMPLE_W-1:0]  s_entry_value,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]  m_shaped_sample
);

    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = (NW > ENTRIES_W) ? NW : ENTRIES_W;

    logic [GAIN_W-1:0]    mix_gain_reg;
    logic [ENTRIES_W-1:0] entries_reg;
    logic [GAIN_W-1:0]    gain_eff;
    logic [CW-1:0]        ent_ext;
    logic [NW-1:0]        n_eff;

    logic                 idx_valid;
    logic                 idx_ready;
    tws_req_t             idx_req;
    logic [NW-1:0]        idx_idx;
    logic [FRAC_W-1:0]    idx_frac;

    logic                 lk_valid;
    logic                 lk_ready;
    tws_interp_t          lk_item;

    // Config registers: the user must write them only while the pipeline is drained; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_gain_reg <= GAIN_RST;
            entries_reg  <= ENTRIES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MIX_GAIN:       mix_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_ENTRIES_IN_USE: entries_reg  <= cfg_data[ENTRIES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp gain to one and the entry count to 2..TABLE_DEPTH.
    assign gain_eff = (mix_gain_reg > GAIN_ONE) ? GAIN_ONE : mix_gain_reg;
    assign ent_ext  = CW'(entries_reg);

    always_comb begin
        priority if (ent_ext < CW'(2)) begin
            n_eff = NW'(2);
        end else if (ent_ext > CW'(TABLE_DEPTH)) begin
            n_eff = NW'(TABLE_DEPTH);
        end else begin
            n_eff = NW'(ent_ext);
        end
    end

    tws_index #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_index (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_valid),
        .in_ready       (s_ready),
        .in_req_type    (s_req_type),
        .in_sample      (s_sample),
        .in_entry_index (s_entry_index),
        .in_entry_value (s_entry_value),
        .n_eff          (n_eff),
        .out_valid      (idx_valid),
        .out_ready      (idx_ready),
        .out_req        (idx_req),
        .out_idx        (idx_idx),
        .out_frac       (idx_frac)
    );

    tws_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_lookup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (idx_valid),
        .in_ready  (idx_ready),
        .in_req    (idx_req),
        .in_idx    (idx_idx),
        .in_frac   (idx_frac),
        .n_eff     (n_eff),
        .out_valid (lk_valid),
        .out_ready (lk_ready),
        .out_item  (lk_item)
    );

    tws_mix u_mix (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (lk_valid),
        .in_ready   (lk_ready),
        .in_item    (lk_item),
        .gain       (gain_eff),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_sample (m_shaped_sample)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while the result side is free");
`endif

endmodule
